// ===== hw/rtl/pba_pkg.sv =====
// Shared types, constants and write-port bundle for the identifier allocator.
`timescale 1ns / 1ps

package pba_pkg;

	// Field widths of the request and response channels.
	localparam int PID_W   = 10;
	localparam int CNT_W   = 7;
	localparam int PN_W    = 32;
	localparam int STAT_W  = 3;
	localparam int MODE_W  = 2;

	// Identifier space and batch limit.
	localparam int MAX_PID   = 1023;
	localparam int MAX_BATCH = 64;

	// Busy bitmap organization: one word holds the busy bits of WORD_W identifiers.
	localparam int WORD_W   = 32;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int WORD_CNT = (MAX_PID + 1) / WORD_W;
	localparam int WIDX_W   = $clog2(WORD_CNT);
	localparam int OWN_DEPTH = MAX_PID + 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC_MANY  = 2'd0,
		MODE_ALLOC_NAMED = 2'd1,
		MODE_FREE_ALL    = 2'd2,
		MODE_FREE_NAMED  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_BUSY      = 3'd1,
		STAT_RANGE     = 3'd2,
		STAT_NOT_ALLOC = 3'd3,
		STAT_EXHAUSTED = 3'd4,
		STAT_NONE      = 3'd5,
		STAT_BAD_COUNT = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SCAN,
		ST_NAMED,
		ST_FREE_ALL,
		ST_EXHAUST,
		ST_ERROR
	} state_t;

	// Write requests from the sequencer to the storage.
	typedef struct packed {
		logic              word_we;
		logic [WIDX_W-1:0] word_addr;
		logic [WORD_W-1:0] word_data;
		logic              clr_all;
		logic              own_we;
		logic [PID_W-1:0]  own_addr;
		logic [PN_W-1:0]   own_data;
	} store_wr_t;

endpackage

// ===== hw/rtl/pba_req_if.sv =====
// Request channel: valid/ready handshake with mode, identifier and count.
`timescale 1ns / 1ps

interface pba_req_if;
	logic                      valid;
	logic                      ready;
	logic [pba_pkg::MODE_W-1:0] mode;
	logic [pba_pkg::PID_W-1:0]  pid;
	logic [pba_pkg::CNT_W-1:0]  count;

	modport source (output valid, output mode, output pid, output count, input ready);
	modport sink   (input valid, input mode, input pid, input count, output ready);
endinterface

// ===== hw/rtl/pba_rsp_if.sv =====
// Response channel: valid/ready handshake with one allocator result.
`timescale 1ns / 1ps

interface pba_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [pba_pkg::STAT_W-1:0] status;
	logic [pba_pkg::PID_W-1:0]  pid_out;
	logic [pba_pkg::PN_W-1:0]   process_number;
	logic [pba_pkg::PID_W-1:0]  released_count;
	logic                       last;

	modport source (output valid, output status, output pid_out, output process_number,
		output released_count, output last, input ready);
	modport sink   (input valid, input status, input pid_out, input process_number,
		input released_count, input last, output ready);
endinterface

// ===== hw/rtl/pba_find.sv =====
// Search unit: position of the lowest clear bit of one bitmap word.
`timescale 1ns / 1ps

module pba_find (
	input  logic [pba_pkg::WORD_W-1:0] word,
	output logic                       found,
	output logic [pba_pkg::BIT_W-1:0]  idx
);
	import pba_pkg::*;

	// Priority encoder; the lowest clear bit wins.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				idx   = BIT_W'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/pba_store.sv =====
// Busy bitmap words with per-word valid bits, and the owner number memory.
`timescale 1ns / 1ps

module pba_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pba_pkg::store_wr_t         wr,
	input  logic [pba_pkg::WIDX_W-1:0] word_raddr,
	input  logic [pba_pkg::PID_W-1:0]  own_raddr,
	output logic [pba_pkg::WORD_W-1:0] word_rdata,
	output logic [pba_pkg::PN_W-1:0]   own_rdata
);
	import pba_pkg::*;

	logic [WORD_W-1:0] word_mem [WORD_CNT];
	logic [PN_W-1:0]   own_mem  [OWN_DEPTH];
	logic [WORD_CNT-1:0] word_vld_q;
	logic [WORD_W-1:0] word_rd_q;
	logic              word_rv_q;
	logic [PN_W-1:0]   own_rd_q;

	// A word that was never written since reset or the last release-all reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			word_rv_q  <= 1'b0;
		end else begin
			word_rv_q <= word_vld_q[word_raddr];
			if (wr.clr_all) begin
				word_vld_q <= '0;
			end else if (wr.word_we) begin
				word_vld_q[wr.word_addr] <= 1'b1;
			end
		end
	end

	// Bitmap word memory with registered read.
	always_ff @(posedge clk) begin
		if (wr.word_we) begin
			word_mem[wr.word_addr] <= wr.word_data;
		end
		word_rd_q <= word_mem[word_raddr];
	end

	// Owner number memory with registered read.
	always_ff @(posedge clk) begin
		if (wr.own_we) begin
			own_mem[wr.own_addr] <= wr.own_data;
		end
		own_rd_q <= own_mem[own_raddr];
	end

	assign word_rdata = word_rv_q ? word_rd_q : '0;
	assign own_rdata  = own_rd_q;

endmodule

// ===== hw/rtl/pid_bitmap_allocator_unit.sv =====
// Top level of the identifier allocator: request decode, sequencer and result register.
// Allocate-many passes through ST_READ, ST_LOAD and ST_SCAN for each bitmap word visited, the search unit
// examining one word per pass, and grants one identifier per scan step while the result register is free.
// Named operations pass through ST_READ, ST_LOAD and ST_NAMED; release-all goes straight to ST_FREE_ALL.
// Throughput: one request at a time; the next is taken once the last result is registered.
// Reset clears the bitmap valid bits, the process counter and the busy count at once.
`timescale 1ns / 1ps

module pid_bitmap_allocator_unit (
	input  logic clk,
	input  logic arst_n,
	pba_req_if.sink   req,
	pba_rsp_if.source rsp
);
	import pba_pkg::*;

	state_t state_q, state_d;

	// Request registers.
	mode_t             mode_q;
	logic [PID_W-1:0]  pid_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  granted_q;
	logic [WIDX_W-1:0] wd_q;
	logic [WORD_W-1:0] cur_q;
	status_t           err_q;

	// Allocator state registers.
	logic [PN_W-1:0]  pc_q;
	logic [PID_W-1:0] busy_cnt_q;

	// Result register.
	logic              rsp_vld_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [PID_W-1:0]  rsp_pid_q;
	logic [PN_W-1:0]   rsp_pn_q;
	logic [PID_W-1:0]  rsp_rel_q;
	logic              rsp_last_q;

	// Sequencer outputs.
	logic              accept;
	logic              emit;
	status_t           e_status;
	logic [PID_W-1:0]  e_pid;
	logic [PN_W-1:0]   e_pn;
	logic [PID_W-1:0]  e_rel;
	logic              e_last;
	logic              grant;
	logic              free_one;
	logic              wd_inc;
	logic              cur_from_mem;
	logic              cur_set;
	store_wr_t         wr;

	logic              out_free;
	logic [WORD_W-1:0] scan_word;
	logic              find_ok;
	logic [BIT_W-1:0]  find_idx;
	logic [WORD_W-1:0] word_rdata;
	logic [PN_W-1:0]   own_rdata;
	logic [PN_W-1:0]   pc_next;
	logic [PID_W-1:0]  scan_id;
	logic              pid_bad;
	logic              cnt_bad;

	pba_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.word_raddr (wd_q),
		.own_raddr  (pid_q),
		.word_rdata (word_rdata),
		.own_rdata  (own_rdata)
	);

	// Identifier zero is never handed out, so it looks busy to the search.
	assign scan_word = cur_q | ((wd_q == '0) ? WORD_W'(1) : '0);

	pba_find u_find (
		.word  (scan_word),
		.found (find_ok),
		.idx   (find_idx)
	);

	assign out_free = !rsp_vld_q || rsp.ready;
	assign pc_next  = pc_q + PN_W'(1);
	assign scan_id  = {wd_q, find_idx};
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign pid_bad   = (req.pid == '0) || (32'(req.pid) > MAX_PID);
	assign cnt_bad   = (req.count == '0) || (32'(req.count) > MAX_BATCH);

	// Next state, result and storage write control.
	always_comb begin
		state_d      = state_q;
		emit         = 1'b0;
		e_status     = STAT_OK;
		e_pid        = '0;
		e_pn         = '0;
		e_rel        = '0;
		e_last       = 1'b1;
		grant        = 1'b0;
		free_one     = 1'b0;
		wd_inc       = 1'b0;
		cur_from_mem = 1'b0;
		cur_set      = 1'b0;
		wr           = '0;
		wr.word_addr = wd_q;
		wr.word_data = cur_q;
		wr.own_addr  = pid_q;
		wr.own_data  = pc_next;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode_t'(req.mode))
						MODE_ALLOC_MANY:  state_d = cnt_bad ? ST_ERROR : ST_READ;
						MODE_FREE_ALL:    state_d = ST_FREE_ALL;
						MODE_ALLOC_NAMED,
						MODE_FREE_NAMED:  state_d = pid_bad ? ST_ERROR : ST_READ;
						default:          state_d = ST_ERROR;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cur_from_mem = 1'b1;
				state_d = (mode_q == MODE_ALLOC_MANY) ? ST_SCAN : ST_NAMED;
			end
			ST_SCAN: begin
				if (find_ok) begin
					if (out_free) begin
						emit     = 1'b1;
						grant    = 1'b1;
						cur_set  = 1'b1;
						e_pid    = scan_id;
						e_pn     = pc_next;
						e_last   = (granted_q + CNT_W'(1)) == count_q;
						wr.own_we    = 1'b1;
						wr.own_addr  = scan_id;
						if (e_last) begin
							wr.word_we   = 1'b1;
							wr.word_data = cur_q | (WORD_W'(1) << find_idx);
							state_d      = ST_IDLE;
						end
					end
				end else begin
					// Word is full: write it back and move on or give up.
					wr.word_we = 1'b1;
					if (wd_q == WIDX_W'(WORD_CNT - 1)) begin
						state_d = ST_EXHAUST;
					end else begin
						wd_inc  = 1'b1;
						state_d = ST_READ;
					end
				end
			end
			ST_NAMED: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (mode_q == MODE_ALLOC_NAMED) begin
						if (cur_q[pid_q[BIT_W-1:0]]) begin
							e_status = STAT_BUSY;
						end else begin
							grant        = 1'b1;
							e_pid        = pid_q;
							e_pn         = pc_next;
							wr.own_we    = 1'b1;
							wr.word_we   = 1'b1;
							wr.word_data = cur_q | (WORD_W'(1) << pid_q[BIT_W-1:0]);
						end
					end else begin
						if (!cur_q[pid_q[BIT_W-1:0]]) begin
							e_status = STAT_NOT_ALLOC;
						end else begin
							free_one     = 1'b1;
							e_pid        = pid_q;
							e_pn         = own_rdata;
							wr.word_we   = 1'b1;
							wr.word_data = cur_q & ~(WORD_W'(1) << pid_q[BIT_W-1:0]);
						end
					end
				end
			end
			ST_FREE_ALL: begin
				if (out_free) begin
					emit       = 1'b1;
					wr.clr_all = 1'b1;
					e_status   = (busy_cnt_q == '0) ? STAT_NONE : STAT_OK;
					e_rel      = busy_cnt_q;
					state_d    = ST_IDLE;
				end
			end
			ST_EXHAUST: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = STAT_EXHAUSTED;
					state_d  = ST_IDLE;
				end
			end
			ST_ERROR: begin
				if (out_free) begin
					emit     = 1'b1;
					e_status = err_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= '0;
			busy_cnt_q <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (grant) begin
				pc_q       <= pc_next;
				busy_cnt_q <= busy_cnt_q + PID_W'(1);
			end else if (free_one) begin
				busy_cnt_q <= busy_cnt_q - PID_W'(1);
			end else if (wr.clr_all) begin
				busy_cnt_q <= '0;
			end
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Request capture and working word.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode_t'(req.mode);
			pid_q     <= req.pid;
			count_q   <= req.count;
			granted_q <= '0;
			err_q     <= (mode_t'(req.mode) == MODE_ALLOC_MANY) ? STAT_BAD_COUNT : STAT_RANGE;
			wd_q      <= (mode_t'(req.mode) == MODE_ALLOC_MANY) ? '0
				: req.pid[PID_W-1 -: WIDX_W];
		end else begin
			if (wd_inc) begin
				wd_q <= wd_q + WIDX_W'(1);
			end
			if (cur_set) begin
				granted_q <= granted_q + CNT_W'(1);
			end
		end
		if (cur_from_mem) begin
			cur_q <= word_rdata;
		end else if (cur_set) begin
			cur_q <= cur_q | (WORD_W'(1) << find_idx);
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= e_status;
			rsp_pid_q    <= e_pid;
			rsp_pn_q     <= e_pn;
			rsp_rel_q    <= e_rel;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.pid_out        = rsp_pid_q;
	assign rsp.process_number = rsp_pn_q;
	assign rsp.released_count = rsp_rel_q;
	assign rsp.last           = rsp_last_q;

endmodule
